/* design/dbd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Days between dates: shared package
// Field widths, reciprocal constants for division by 100, and the calendar
// tables for month lengths and days before each month.
// ----------------------------------------------------------------------------
package dbd_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 22;

	// Largest year that is kept; larger years saturate here.
	localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

	// floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for every x below 2^14.
	localparam int MUL_B_W = 13;
	localparam logic [MUL_B_W-1:0] RECIP_100   = 13'd5243;
	localparam int                 RECIP_SHIFT = 19;
	localparam logic [MUL_B_W-1:0] DAYS_YEAR   = 13'd365;
	localparam int PROD_W = YEAR_W + MUL_B_W;
	localparam int QUOT_W = 7;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	// Length of a month in days, February following the leap flag.
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd2:                       len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
			default:                    len = 5'd31;
		endcase
		return len;
	endfunction

	// Days in the months ahead of month m in a common year.
	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
		logic [8:0] n;
		case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

/* design/days_between_dates.sv */
`timescale 1ns / 1ps
`default_nettype none
// An accepted input transaction reaches out_valid through the RUN steps of both
// dates and the DIFF state. The single shared multiplier runs six steps for each
// of the two dates, DIFF forms the difference, waiting while the output register
// is full, and IDLE takes the next transaction; no new input is taken before then.
// in_ready is low from acceptance until the result moves to the output register.
// Reset (arst_n low) clears the sequencer, out_valid and include_last_day.
// ----------------------------------------------------------------------------
// Days between dates
// Converts two Gregorian dates to serial day numbers with one shared
// multiply-accumulate unit and returns the clamped difference.
// ----------------------------------------------------------------------------
module days_between_dates (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_data,
	// Input channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [dbd_pkg::YEAR_W-1:0]    start_year,
	input  wire logic [dbd_pkg::MONTH_W-1:0]   start_month,
	input  wire logic [dbd_pkg::DAY_W-1:0]     start_day,
	input  wire logic [dbd_pkg::YEAR_W-1:0]    end_year,
	input  wire logic [dbd_pkg::MONTH_W-1:0]   end_month,
	input  wire logic [dbd_pkg::DAY_W-1:0]     end_day,
	// Output channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [dbd_pkg::COUNT_W-1:0]        day_count
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIFF} state_t;

	localparam logic [2:0] STEP_LAST = 3'd5;

	state_t                           state_q;
	logic [2:0]                       step_q;
	logic                             date_q;
	logic                             include_last_day_q;
	logic [dbd_pkg::YEAR_W-1:0]       sy_q, ey_q;
	logic [dbd_pkg::MONTH_W-1:0]      sm_q, em_q;
	logic [dbd_pkg::DAY_W-1:0]        sd_q, ed_q;
	logic [dbd_pkg::COUNT_W-1:0]      acc_q, num_a_q, count_q;
	logic [dbd_pkg::QUOT_W-1:0]       c100_q, c400_q;
	logic                             div100_q, div400_q;
	logic                             out_valid_q;

	logic [dbd_pkg::YEAR_W-1:0]       y_cur;
	logic [dbd_pkg::MONTH_W-1:0]      m_cur;
	logic [dbd_pkg::DAY_W-1:0]        d_cur;
	logic [dbd_pkg::YEAR_W-1:0]       mul_a;
	logic [dbd_pkg::MUL_B_W-1:0]      mul_b;
	logic [dbd_pkg::PROD_W-1:0]       prod;
	logic [dbd_pkg::QUOT_W-1:0]       quot;
	logic                             leap;
	logic [dbd_pkg::DAY_W-1:0]        len, d_fix;
	logic [dbd_pkg::COUNT_W-1:0]      tail, num_cur;
	logic [dbd_pkg::COUNT_W:0]        diff;
	logic [dbd_pkg::COUNT_W-1:0]      result;
	logic                             out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign day_count = count_q;
	assign out_free  = !out_valid_q || out_ready;

	// Operands of the date that is being converted.
	always_comb begin
		y_cur = date_q ? ey_q : sy_q;
		m_cur = date_q ? em_q : sm_q;
		d_cur = date_q ? ed_q : sd_q;
	end

	// Shared multiplier: one product per step, operands chosen by the step.
	always_comb begin
		case (step_q)
			3'd0: begin
				mul_a = y_cur;
				mul_b = dbd_pkg::DAYS_YEAR;
			end
			3'd1: begin
				mul_a = y_cur + 14'd99;
				mul_b = dbd_pkg::RECIP_100;
			end
			3'd2: begin
				mul_a = y_cur;
				mul_b = dbd_pkg::RECIP_100;
			end
			3'd3: begin
				mul_a = (y_cur + 14'd399) >> 2;
				mul_b = dbd_pkg::RECIP_100;
			end
			3'd4: begin
				mul_a = y_cur >> 2;
				mul_b = dbd_pkg::RECIP_100;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = dbd_pkg::PROD_W'(mul_a) * dbd_pkg::PROD_W'(mul_b);
		quot = prod[dbd_pkg::RECIP_SHIFT +: dbd_pkg::QUOT_W];
	end

	// Final step of a date: leap rule, day clamp, the (y+3)/4 term, the month offset and the day.
	always_comb begin
		leap    = div400_q || ((y_cur[1:0] == 2'b00) && !div100_q);
		len     = dbd_pkg::month_len(m_cur, leap);
		d_fix   = (d_cur == '0) ? 5'd1 : ((d_cur > len) ? len : d_cur);
		tail    = dbd_pkg::COUNT_W'((y_cur + 14'd3) >> 2)
		        + dbd_pkg::COUNT_W'(dbd_pkg::days_before(m_cur))
		        + dbd_pkg::COUNT_W'(leap && (m_cur > dbd_pkg::MONTH_FEB))
		        + dbd_pkg::COUNT_W'(d_fix);
		num_cur = acc_q + tail;
	end

	// Difference of the two day numbers, zero when start is not before end, plus include_last_day.
	always_comb begin
		diff   = {1'b0, acc_q} - {1'b0, num_a_q};
		result = (diff[dbd_pkg::COUNT_W] ? '0 : diff[dbd_pkg::COUNT_W-1:0])
		       + dbd_pkg::COUNT_W'(include_last_day_q);
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			include_last_day_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			include_last_day_q <= cfg_data;
		end
	end

	// Captured dates; year and month are saturated into range at acceptance, the day is clamped later.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sy_q <= (start_year > dbd_pkg::YEAR_MAX) ? dbd_pkg::YEAR_MAX : start_year;
			ey_q <= (end_year > dbd_pkg::YEAR_MAX) ? dbd_pkg::YEAR_MAX : end_year;
			sm_q <= (start_month == '0) ? dbd_pkg::MONTH_JAN :
			        ((start_month > dbd_pkg::MONTH_DEC) ? dbd_pkg::MONTH_DEC : start_month);
			em_q <= (end_month == '0) ? dbd_pkg::MONTH_JAN :
			        ((end_month > dbd_pkg::MONTH_DEC) ? dbd_pkg::MONTH_DEC : end_month);
			sd_q <= start_day;
			ed_q <= end_day;
		end
	end

	// Accumulator and intermediate quotients of the shared unit.
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			case (step_q)
				3'd0: acc_q <= prod[dbd_pkg::COUNT_W-1:0];
				3'd1: c100_q <= quot;
				3'd2: begin
					div100_q <= (c100_q == quot);
					acc_q    <= acc_q - dbd_pkg::COUNT_W'(c100_q);
				end
				3'd3: c400_q <= quot;
				3'd4: begin
					div400_q <= (c400_q == quot);
					acc_q    <= acc_q + dbd_pkg::COUNT_W'(c400_q);
				end
				default: begin
					acc_q <= num_cur;
					if (!date_q) begin
						num_a_q <= num_cur;
					end
				end
			endcase
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			date_q      <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			// The output register loads a finished count, else drops a taken one.
			if (state_q == ST_DIFF && out_free) begin
				count_q     <= result;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						step_q  <= '0;
						date_q  <= 1'b0;
					end
				end
				ST_RUN: begin
					if (step_q == STEP_LAST) begin
						step_q <= '0;
						date_q <= 1'b1;
						if (date_q) begin
							state_q <= ST_DIFF;
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_DIFF: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// An accepted transaction keeps the input side busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a conversion was starting");

	// The step counter never runs past the last step of a date.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_LAST)
		else $error("step counter out of range");

	// A waiting result is never overwritten by the next one.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIFF && out_valid_q && !out_ready) |=> (state_q == ST_DIFF))
		else $error("result written over a pending output");

	// Every delivered count lies within the span of the calendar range.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (day_count <= 22'd3652426))
		else $error("day count out of range");

endmodule
`default_nettype wire

/* dv/days_between_dates_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Days between dates: testbench
// Sends pairs of dates through the valid/ready input channel and checks each
// day_count against a predictor of the Gregorian day count. Runs under both
// settings of include_last_day, with random idling on both channels, a long
// receiver hold-off and a full drain pause of the sender.
// ----------------------------------------------------------------------------
module days_between_dates_tb;

	localparam int YEAR_W  = dbd_pkg::YEAR_W;
	localparam int MONTH_W = dbd_pkg::MONTH_W;
	localparam int DAY_W   = dbd_pkg::DAY_W;
	localparam int COUNT_W = dbd_pkg::COUNT_W;

	localparam int CLK_PERIOD  = 20;
	localparam int LATENCY     = 14;
	localparam int MAX_CYCLES  = 200000;
	localparam int HOLD_AT     = 150;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_AFTER = 700;

	typedef struct packed {
		logic [YEAR_W-1:0]  s_year;
		logic [MONTH_W-1:0] s_month;
		logic [DAY_W-1:0]   s_day;
		logic [YEAR_W-1:0]  e_year;
		logic [MONTH_W-1:0] e_month;
		logic [DAY_W-1:0]   e_day;
	} date_pair_t;

	typedef struct {
		date_pair_t          dates;
		logic [COUNT_W-1:0]  count;
	} span_expect_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                cfg_data = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [YEAR_W-1:0]   start_year = '0;
	logic [MONTH_W-1:0]  start_month = '0;
	logic [DAY_W-1:0]    start_day = '0;
	logic [YEAR_W-1:0]   end_year = '0;
	logic [MONTH_W-1:0]  end_month = '0;
	logic [DAY_W-1:0]    end_day = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [COUNT_W-1:0]  day_count;

	// Predictor copy of the configuration register.
	bit                  last_day_cfg = 1'b0;

	date_pair_t          pending_pairs[$];
	span_expect_t        open_spans[$];
	bit                  in_taken = 1'b0;
	int                  pairs_queued = 0;
	int                  pairs_accepted = 0;
	int                  spans_answered = 0;
	int                  results_seen = 0;
	int                  error_count = 0;
	int                  cfg_writes = 0;
	int                  in_idle_pct = 38;
	int                  out_idle_pct = 38;
	int                  hold_left = 0;
	bit                  hold_done = 1'b0;

	days_between_dates u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.start_year  (start_year),
		.start_month (start_month),
		.start_day   (start_day),
		.end_year    (end_year),
		.end_month   (end_month),
		.end_day     (end_day),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.day_count   (day_count)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Calendar helpers for the predictor and the stimulus.
	function automatic bit is_leap(input int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned month_length(input int unsigned m, input bit leap_year);
		case (m)
			2:           return leap_year ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	// Serial day number of a date after the out-of-range fields are clamped.
	function automatic int unsigned serial_day(input logic [YEAR_W-1:0] yr,
			input logic [MONTH_W-1:0] mo, input logic [DAY_W-1:0] dy);
		int unsigned y;
		int unsigned m;
		int unsigned d;
		int unsigned n;
		bit          lp;
		y = yr;
		m = mo;
		d = dy;
		if (y > 9999)
			y = 9999;
		if (m < 1)
			m = 1;
		if (m > 12)
			m = 12;
		lp = is_leap(y);
		if (d < 1)
			d = 1;
		if (d > month_length(m, lp))
			d = month_length(m, lp);
		n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
		for (int unsigned k = 1; k < m; k++)
			n += month_length(k, lp);
		return n + d;
	endfunction

	// Expected day_count for one pair under the current register setting.
	function automatic logic [COUNT_W-1:0] predict_day_count(input date_pair_t p);
		int unsigned a;
		int unsigned b;
		int unsigned span;
		a = serial_day(p.s_year, p.s_month, p.s_day);
		b = serial_day(p.e_year, p.e_month, p.e_day);
		span = (a < b) ? (b - a) : 0;
		span += last_day_cfg;
		return span[COUNT_W-1:0];
	endfunction

	function automatic void pick_date(output logic [YEAR_W-1:0] y,
			output logic [MONTH_W-1:0] m, output logic [DAY_W-1:0] d);
		y = YEAR_W'($urandom_range(0, 9999));
		m = MONTH_W'($urandom_range(1, 12));
		d = DAY_W'($urandom_range(1, month_length(m, is_leap(y))));
	endfunction

	// Mostly well-formed pairs, with some equal, reversed and raw-noise pairs.
	function automatic date_pair_t random_pair();
		date_pair_t  p;
		date_pair_t  t;
		int unsigned mode;
		int unsigned order;
		int unsigned a;
		int unsigned b;
		mode = $urandom_range(0, 99);
		order = ($urandom_range(0, 4) != 0) ? 1 : 0;
		pick_date(p.s_year, p.s_month, p.s_day);
		pick_date(p.e_year, p.e_month, p.e_day);
		if (mode < 12) begin
			p.s_year  = YEAR_W'($urandom_range(0, 16383));
			p.s_month = MONTH_W'($urandom_range(0, 15));
			p.s_day   = DAY_W'($urandom_range(0, 31));
			p.e_year  = YEAR_W'($urandom_range(0, 16383));
			p.e_month = MONTH_W'($urandom_range(0, 15));
			p.e_day   = DAY_W'($urandom_range(0, 31));
			order = 0;
		end else if (mode < 17) begin
			p.e_year  = p.s_year;
			p.e_month = p.s_month;
			p.e_day   = p.s_day;
		end else if (mode < 25) begin
			order = 2;
		end else if (mode < 35) begin
			p.e_year  = p.s_year;
			p.e_month = p.s_month;
			p.e_day   = DAY_W'($urandom_range(1, 28));
		end else if (mode < 50) begin
			p.e_year = (p.s_year < 9999) ? p.s_year + YEAR_W'($urandom_range(0, 1)) : p.s_year;
		end
		a = serial_day(p.s_year, p.s_month, p.s_day);
		b = serial_day(p.e_year, p.e_month, p.e_day);
		if ((order == 1 && a > b) || (order == 2 && a < b)) begin
			t = p;
			p.s_year  = t.e_year;
			p.s_month = t.e_month;
			p.s_day   = t.e_day;
			p.e_year  = t.s_year;
			p.e_month = t.s_month;
			p.e_day   = t.s_day;
		end
		return p;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic push_pair(input int sy, input int sm, input int sd,
			input int ey, input int em, input int ed);
		pending_pairs.push_back('{s_year: YEAR_W'(sy), s_month: MONTH_W'(sm),
			s_day: DAY_W'(sd), e_year: YEAR_W'(ey), e_month: MONTH_W'(em),
			e_day: DAY_W'(ed)});
		pairs_queued++;
	endtask

	// Field extremes, leap rules, clamping and ordering corner cases.
	task automatic push_corner_pairs();
		push_pair(0, 1, 1, 9999, 12, 31);
		push_pair(9999, 12, 31, 0, 1, 1);
		push_pair(2024, 6, 15, 2024, 6, 15);
		push_pair(2024, 6, 16, 2024, 6, 15);
		push_pair(2024, 6, 15, 2024, 6, 16);
		push_pair(2000, 2, 29, 2000, 3, 1);
		push_pair(1900, 2, 29, 1900, 3, 1);
		push_pair(2023, 2, 31, 2024, 2, 31);
		push_pair(0, 2, 29, 0, 3, 1);
		push_pair(1999, 12, 31, 2000, 1, 1);
		push_pair(0, 0, 0, 16383, 15, 31);
		push_pair(16383, 15, 31, 0, 0, 0);
		push_pair(10000, 13, 0, 9999, 12, 1);
		push_pair(2021, 4, 31, 2021, 5, 1);
		push_pair(2021, 0, 15, 2021, 1, 15);
		push_pair(1600, 1, 1, 1700, 1, 1);
		push_pair(1700, 1, 1, 1800, 1, 1);
		push_pair(2100, 2, 29, 2100, 3, 1);
		push_pair(8191, 8, 16, 8192, 8, 16);
		push_pair(5461, 5, 10, 10922, 10, 21);
		push_pair(9999, 11, 30, 16383, 12, 31);
	endtask

	// Returns at a falling edge once every queued pair has been answered.
	task automatic wait_for_drain();
		@(negedge clk);
		while (spans_answered != pairs_queued)
			@(negedge clk);
	endtask

	// One configuration write transaction; called only while the block is idle.
	task automatic write_include_last_day(input bit value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		last_day_cfg = value;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input bit do_write, input bit value, input bit corners,
			input int n_random, input int idle_pct);
		wait_for_drain();
		if (do_write)
			write_include_last_day(value);
		@(posedge clk);
		in_idle_pct  = idle_pct;
		out_idle_pct = idle_pct;
		if (corners)
			push_corner_pairs();
		for (int i = 0; i < n_random; i++) begin
			pending_pairs.push_back(random_pair());
			pairs_queued++;
		end
	endtask

	// Input driver: holds each offered pair until the handshake takes it.
	always @(negedge clk) begin : drive_pairs
		date_pair_t nxt;
		bit         offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_taken)) begin
			// Once, stop offering until every accepted pair has been answered.
			offer = (pending_pairs.size() != 0)
				&& ($urandom_range(0, 99) >= in_idle_pct)
				&& !(pairs_accepted == DRAIN_AFTER && spans_answered != pairs_accepted);
			if (offer) begin
				nxt = pending_pairs.pop_front();
				in_valid    <= 1'b1;
				start_year  <= nxt.s_year;
				start_month <= nxt.s_month;
				start_day   <= nxt.s_day;
				end_year    <= nxt.e_year;
				end_month   <= nxt.e_month;
				end_day     <= nxt.e_day;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls plus one long hold-off that fills the block.
	always @(negedge clk) begin : drive_out_ready
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (results_seen == HOLD_AT && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
		end
	end

	// Scoreboard: check the output transaction first, then record the input one.
	always @(posedge clk) begin : scoreboard
		span_expect_t head;
		date_pair_t   seen;
		if (!arst_n) begin
			in_taken = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (open_spans.size() == 0) begin
					report_mismatch($sformatf("day_count %0d with no date pair pending",
						day_count));
				end else begin
					head = open_spans.pop_front();
					spans_answered++;
					if (day_count !== head.count)
						report_mismatch($sformatf(
							"%0d-%0d-%0d to %0d-%0d-%0d: day_count %0d, expected %0d",
							head.dates.s_year, head.dates.s_month, head.dates.s_day,
							head.dates.e_year, head.dates.e_month, head.dates.e_day,
							day_count, head.count));
				end
			end
			in_taken = in_valid && in_ready;
			if (in_taken) begin
				seen.s_year  = start_year;
				seen.s_month = start_month;
				seen.s_day   = start_day;
				seen.e_year  = end_year;
				seen.e_month = end_month;
				seen.e_day   = end_day;
				open_spans.push_back('{dates: seen, count: predict_day_count(seen)});
				pairs_accepted++;
			end
		end
	end

	// Main sequence: reset, then phases under alternating register settings.
	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		run_phase(1'b0, 1'b0, 1'b1, 0, 38);
		run_phase(1'b1, 1'b1, 1'b1, 280, 38);
		run_phase(1'b1, 1'b0, 1'b0, 280, 0);
		run_phase(1'b1, 1'b1, 1'b0, 270, 38);
		run_phase(1'b1, 1'b0, 1'b0, 270, 38);
		wait_for_drain();
		repeat (4 * LATENCY) @(negedge clk);
		if (open_spans.size() != 0)
			report_mismatch($sformatf("%0d date pairs never answered", open_spans.size()));
		$display("Summary: %0d date pairs checked across %0d register writes,",
			spans_answered, cfg_writes);
		$display("including clamped fields, a long output stall and a drain pause.");
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(CLK_PERIOD * MAX_CYCLES);
		$display("Timeout after %0d cycles", MAX_CYCLES);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
